>>> rtl/small_matrix_alu_unit_assert.svh
// assertion macros for the small matrix alu unit
// needs clk_i and rst_ni in the including module's scope
`ifndef SMALL_MATRIX_ALU_UNIT_ASSERT_SVH
`define SMALL_MATRIX_ALU_UNIT_ASSERT_SVH

// checked only out of reset
`define SMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define SMA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/sma_pkg.sv
// shared types and codes of the small matrix alu unit
// no dependencies
package sma_pkg;

  localparam int DimWidth   = 3;
  localparam int ValueWidth = 32;

  typedef enum logic [2:0] {
    FN_SET_DIMS  = 3'd0,
    FN_WRITE     = 3'd1,
    FN_READ      = 3'd2,
    FN_ADD       = 3'd3,
    FN_SCALE     = 3'd4,
    FN_TRANSPOSE = 3'd5,
    FN_MULTIPLY  = 3'd6,
    FN_NONE      = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_DIM_MISMATCH = 2'd1,
    ST_OUT_OF_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic [ValueWidth-1:0] value;
    status_e               status;
    logic [DimWidth-1:0]   rows;
    logic [DimWidth-1:0]   cols;
  } result_t;

endpackage

>>> rtl/sma_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies
module sma_ram #(
  parameter int Width = 32,
  parameter int Depth = 50,
  localparam int AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/small_matrix_alu_unit.sv
// top level of the small matrix alu unit: sequencer, shared multiplier, result register
// depends on sma_pkg, sma_ram and small_matrix_alu_unit_assert.svh
//
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------------
//  input   | in_valid_i / in_ready_o | func_i target_i row_index_i col_index_i
//          |                         | dim_rows_i dim_cols_i value_in_i
//  output  | out_valid_o/out_ready_i | read_value_o status_o out_rows_o out_cols_o
//
// set dims, write and the none code go from idle straight to the done state; read passes
// through the data state. add and transpose run issue and data per element, scale adds a
// product state, and multiply runs issue, data and product per multiply-accumulate, using
// one multiplier shared by scale and multiply and the single read port of each ram. stores
// sit in two halves; transpose and multiply write the other half and then flip. reset clears
// the per-entry valid bits at once, so no clearing pass runs. one finished transaction waits in
// the output register; a second waits in the done state until the output side takes the first.
module small_matrix_alu_unit #(
  parameter int SIZE       = 5,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          func_i,
  input  logic                target_i,
  input  logic [2:0]          row_index_i,
  input  logic [2:0]          col_index_i,
  input  logic [2:0]          dim_rows_i,
  input  logic [2:0]          dim_cols_i,
  input  logic signed [31:0]  value_in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  read_value_o,
  output logic [1:0]          status_o,
  output logic [2:0]          out_rows_o,
  output logic [2:0]          out_cols_o
);

  localparam int Cells = SIZE * SIZE;
  localparam int Depth = 2 * Cells;
  localparam int AW    = $clog2(Depth);
  localparam int EW    = ELEM_WIDTH;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ISSUE = 6'b000010,
    S_DATA  = 6'b000100,
    S_PROD  = 6'b001000,
    S_FIN   = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  function automatic logic [AW-1:0] cell_addr(input logic bank, input logic [2:0] r,
                                              input logic [2:0] c);
    cell_addr = AW'(int'(bank) * Cells + int'(r) * SIZE + int'(c));
  endfunction

  state_e state_q, state_d;
  sma_pkg::func_e op_q, op_d;
  logic tgt_q, tgt_d;
  logic [EW-1:0] scalar_q, scalar_d, acc_q, acc_d, prod_q, prod_d;
  logic [2:0] i_q, i_d, j_q, j_d, k_q, k_d, ni_q, ni_d, nj_q, nj_d, nk_q, nk_d;
  logic [2:0] lr_q, lr_d, lc_q, lc_d, rr_q, rr_d, rc_q, rc_d;
  logic lbank_q, lbank_d, rbank_q, rbank_d;
  logic [Depth-1:0] lvld_q, lvld_d, rvld_q, rvld_d;
  logic lrv_q, rrv_q;
  sma_pkg::result_t res_q, res_d, out_q, out_d;
  logic out_valid_q, out_valid_d;

  logic [AW-1:0] l_raddr, r_raddr, w_addr;
  logic [EW-1:0] l_rdata, r_rdata, w_data;
  logic w_en, w_tgt, l_we, r_we;

  logic [63:0] v64, sd64;
  logic [EW-1:0] v_elem, ld, rdd, sd, mul_a, mul_b, product, acc_sum;
  logic [2:0] t_rows, t_cols, adv_i, adv_j;
  logic t_bank, oob;
  state_e adv_state;

  assign v64     = 64'(value_in_i);
  assign v_elem  = v64[EW-1:0];
  assign ld      = lrv_q ? l_rdata : '0;
  assign rdd     = rrv_q ? r_rdata : '0;
  assign sd      = tgt_q ? rdd : ld;
  assign sd64    = 64'(sd);
  assign mul_a   = (op_q == sma_pkg::FN_MULTIPLY) ? ld : sd;
  assign mul_b   = (op_q == sma_pkg::FN_MULTIPLY) ? rdd : scalar_q;
  assign product = mul_a * mul_b;
  assign acc_sum = acc_q + prod_q;

  assign t_rows = target_i ? rr_q : lr_q;
  assign t_cols = target_i ? rc_q : lc_q;
  assign t_bank = target_i ? rbank_q : lbank_q;
  assign oob    = (row_index_i >= t_rows) || (col_index_i >= t_cols);

  assign in_ready_o = (state_q == S_IDLE);
  assign l_we = w_en & ~w_tgt;
  assign r_we = w_en & w_tgt;

  // step to the next element in row-major order
  always_comb begin
    adv_i = i_q;
    adv_j = j_q + 3'd1;
    adv_state = S_ISSUE;
    if (j_q == nj_q - 3'd1) begin
      adv_j = 3'd0;
      if (i_q == ni_q - 3'd1) begin
        adv_state = S_FIN;
      end else begin
        adv_i = i_q + 3'd1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    op_d = op_q;
    tgt_d = tgt_q;
    scalar_d = scalar_q;
    acc_d = acc_q;
    prod_d = prod_q;
    i_d = i_q;
    j_d = j_q;
    k_d = k_q;
    ni_d = ni_q;
    nj_d = nj_q;
    nk_d = nk_q;
    lr_d = lr_q;
    lc_d = lc_q;
    rr_d = rr_q;
    rc_d = rc_q;
    lbank_d = lbank_q;
    rbank_d = rbank_q;
    lvld_d = lvld_q;
    rvld_d = rvld_q;
    res_d = res_q;
    out_d = out_q;
    out_valid_d = out_valid_q;
    w_en = 1'b0;
    w_tgt = 1'b0;
    w_addr = '0;
    w_data = '0;
    l_raddr = '0;
    r_raddr = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d = sma_pkg::func_e'(func_i);
          tgt_d = target_i;
          scalar_d = v_elem;
          i_d = 3'd0;
          j_d = 3'd0;
          k_d = 3'd0;
          acc_d = '0;
          res_d.value = '0;
          res_d.status = sma_pkg::ST_OK;
          res_d.rows = t_rows;
          res_d.cols = t_cols;
          state_d = S_DONE;
          unique case (sma_pkg::func_e'(func_i))
            sma_pkg::FN_SET_DIMS: begin
              if (int'(dim_rows_i) > SIZE || int'(dim_cols_i) > SIZE) begin
                res_d.status = sma_pkg::ST_OUT_OF_RANGE;
              end else begin
                if (target_i) begin
                  rr_d = dim_rows_i;
                  rc_d = dim_cols_i;
                end else begin
                  lr_d = dim_rows_i;
                  lc_d = dim_cols_i;
                end
                res_d.rows = dim_rows_i;
                res_d.cols = dim_cols_i;
              end
            end
            sma_pkg::FN_WRITE: begin
              if (oob) begin
                res_d.status = sma_pkg::ST_OUT_OF_RANGE;
              end else begin
                w_en = 1'b1;
                w_tgt = target_i;
                w_addr = cell_addr(t_bank, row_index_i, col_index_i);
                w_data = v_elem;
              end
            end
            sma_pkg::FN_READ: begin
              if (oob) begin
                res_d.status = sma_pkg::ST_OUT_OF_RANGE;
              end else begin
                l_raddr = cell_addr(lbank_q, row_index_i, col_index_i);
                r_raddr = cell_addr(rbank_q, row_index_i, col_index_i);
                state_d = S_DATA;
              end
            end
            sma_pkg::FN_ADD: begin
              res_d.rows = lr_q;
              res_d.cols = lc_q;
              if (lr_q != rr_q || lc_q != rc_q) begin
                res_d.status = sma_pkg::ST_DIM_MISMATCH;
              end else begin
                ni_d = lr_q;
                nj_d = lc_q;
                state_d = (lr_q == 3'd0 || lc_q == 3'd0) ? S_FIN : S_ISSUE;
              end
            end
            sma_pkg::FN_SCALE: begin
              ni_d = t_rows;
              nj_d = t_cols;
              state_d = (t_rows == 3'd0 || t_cols == 3'd0) ? S_FIN : S_ISSUE;
            end
            sma_pkg::FN_TRANSPOSE: begin
              // result goes to the other half, which must read as zero
              for (int n = 0; n < Cells; n++) begin
                if (target_i) begin
                  rvld_d[AW'(int'(!rbank_q) * Cells + n)] = 1'b0;
                end else begin
                  lvld_d[AW'(int'(!lbank_q) * Cells + n)] = 1'b0;
                end
              end
              ni_d = t_rows;
              nj_d = t_cols;
              state_d = (t_rows == 3'd0 || t_cols == 3'd0) ? S_FIN : S_ISSUE;
            end
            sma_pkg::FN_MULTIPLY: begin
              res_d.rows = lr_q;
              res_d.cols = lc_q;
              if (lc_q != rr_q) begin
                res_d.status = sma_pkg::ST_DIM_MISMATCH;
              end else begin
                for (int n = 0; n < Cells; n++) begin
                  lvld_d[AW'(int'(!lbank_q) * Cells + n)] = 1'b0;
                end
                ni_d = lr_q;
                nj_d = rc_q;
                nk_d = lc_q;
                state_d = (lr_q == 3'd0 || rc_q == 3'd0 || lc_q == 3'd0) ? S_FIN : S_ISSUE;
              end
            end
            sma_pkg::FN_NONE: begin
            end
          endcase
        end
      end
      S_ISSUE: begin
        if (op_q == sma_pkg::FN_MULTIPLY) begin
          l_raddr = cell_addr(lbank_q, i_q, k_q);
          r_raddr = cell_addr(rbank_q, k_q, j_q);
        end else begin
          l_raddr = cell_addr(lbank_q, i_q, j_q);
          r_raddr = cell_addr(rbank_q, i_q, j_q);
        end
        state_d = S_DATA;
      end
      S_DATA: begin
        priority case (op_q)
          sma_pkg::FN_READ: begin
            res_d.value = sd64[31:0];
            state_d = S_DONE;
          end
          sma_pkg::FN_ADD: begin
            w_en = 1'b1;
            w_tgt = 1'b0;
            w_addr = cell_addr(lbank_q, i_q, j_q);
            w_data = ld + rdd;
            state_d = adv_state;
            i_d = adv_i;
            j_d = adv_j;
          end
          sma_pkg::FN_TRANSPOSE: begin
            w_en = 1'b1;
            w_tgt = tgt_q;
            w_addr = cell_addr(tgt_q ? !rbank_q : !lbank_q, j_q, i_q);
            w_data = sd;
            state_d = adv_state;
            i_d = adv_i;
            j_d = adv_j;
          end
          sma_pkg::FN_SCALE, sma_pkg::FN_MULTIPLY: begin
            prod_d = product;
            state_d = S_PROD;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_PROD: begin
        if (op_q == sma_pkg::FN_SCALE) begin
          w_en = 1'b1;
          w_tgt = tgt_q;
          w_addr = cell_addr(tgt_q ? rbank_q : lbank_q, i_q, j_q);
          w_data = prod_q;
          state_d = adv_state;
          i_d = adv_i;
          j_d = adv_j;
        end else if (k_q == nk_q - 3'd1) begin
          w_en = 1'b1;
          w_tgt = 1'b0;
          w_addr = cell_addr(!lbank_q, i_q, j_q);
          w_data = acc_sum;
          acc_d = '0;
          k_d = 3'd0;
          state_d = adv_state;
          i_d = adv_i;
          j_d = adv_j;
        end else begin
          acc_d = acc_sum;
          k_d = k_q + 3'd1;
          state_d = S_ISSUE;
        end
      end
      S_FIN: begin
        priority case (op_q)
          sma_pkg::FN_ADD: begin
            rvld_d = '0;
            rr_d = 3'd0;
            rc_d = 3'd0;
          end
          sma_pkg::FN_TRANSPOSE: begin
            if (tgt_q) begin
              rbank_d = !rbank_q;
              rr_d = rc_q;
              rc_d = rr_q;
              res_d.rows = rc_q;
              res_d.cols = rr_q;
            end else begin
              lbank_d = !lbank_q;
              lr_d = lc_q;
              lc_d = lr_q;
              res_d.rows = lc_q;
              res_d.cols = lr_q;
            end
          end
          sma_pkg::FN_MULTIPLY: begin
            lbank_d = !lbank_q;
            lc_d = rc_q;
            res_d.cols = rc_q;
            rvld_d = '0;
            rr_d = 3'd0;
            rc_d = 3'd0;
          end
          default: begin
          end
        endcase
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d = res_q;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
    endcase

    if (w_en) begin
      if (w_tgt) begin
        rvld_d[w_addr] = 1'b1;
      end else begin
        lvld_d[w_addr] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
      lr_q <= 3'd0;
      lc_q <= 3'd0;
      rr_q <= 3'd0;
      rc_q <= 3'd0;
      lbank_q <= 1'b0;
      rbank_q <= 1'b0;
      lvld_q <= '0;
      rvld_q <= '0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      lr_q <= lr_d;
      lc_q <= lc_d;
      rr_q <= rr_d;
      rc_q <= rc_d;
      lbank_q <= lbank_d;
      rbank_q <= rbank_d;
      lvld_q <= lvld_d;
      rvld_q <= rvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    tgt_q <= tgt_d;
    scalar_q <= scalar_d;
    acc_q <= acc_d;
    prod_q <= prod_d;
    i_q <= i_d;
    j_q <= j_d;
    k_q <= k_d;
    ni_q <= ni_d;
    nj_q <= nj_d;
    nk_q <= nk_d;
    res_q <= res_d;
    out_q <= out_d;
    // valid bit travels with the registered ram read
    lrv_q <= lvld_q[l_raddr];
    rrv_q <= rvld_q[r_raddr];
  end

  sma_ram #(.Width(EW), .Depth(Depth)) u_left_ram (
    .clk_i  (clk_i),
    .we_i   (l_we),
    .waddr_i(w_addr),
    .wdata_i(w_data),
    .raddr_i(l_raddr),
    .rdata_o(l_rdata)
  );

  sma_ram #(.Width(EW), .Depth(Depth)) u_right_ram (
    .clk_i  (clk_i),
    .we_i   (r_we),
    .waddr_i(w_addr),
    .wdata_i(w_data),
    .raddr_i(r_raddr),
    .rdata_o(r_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_q.value;
  assign status_o     = out_q.status;
  assign out_rows_o   = out_q.rows;
  assign out_cols_o   = out_q.cols;

`include "small_matrix_alu_unit_assert.svh"

  `SMA_ASSERT(a_issue_in_bounds, (state_q == S_ISSUE) |-> (i_q < ni_q && j_q < nj_q && (op_q != sma_pkg::FN_MULTIPLY || k_q < nk_q)), "element counters out of bounds")
  `SMA_ASSERT(a_prod_ops, (state_q == S_PROD) |-> (op_q == sma_pkg::FN_SCALE || op_q == sma_pkg::FN_MULTIPLY), "product stage entered by wrong op")
  `SMA_ASSERT(a_right_cleared, (state_q == S_FIN && (op_q == sma_pkg::FN_ADD || op_q == sma_pkg::FN_MULTIPLY)) |=> (rr_q == 3'd0 && rc_q == 3'd0 && rvld_q == '0), "right matrix not cleared")

endmodule
